[rtl/core/qoq_pkg.sv]
// ----------------------------------------------------------------------------
// qoq_pkg
// Shared types, sizes and helper functions of the queue-of-queues buffer.
// ----------------------------------------------------------------------------
package qoq_pkg;

  localparam int NUM_QUEUES  = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;

  localparam int QW        = $clog2(NUM_QUEUES);               // queue number
  localparam int PW        = $clog2(QUEUE_DEPTH);              // slot pointer
  localparam int FW        = $clog2(QUEUE_DEPTH + 1);          // fill count
  localparam int MCW       = $clog2(NUM_QUEUES + 1);           // main count
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQW      = $clog2(CQ_DEPTH);
  localparam int CQCW     = $clog2(CQ_DEPTH + 1);

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQW      = $clog2(OQ_DEPTH);
  localparam int OQCW     = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_ATTACH  = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_ATTACHED = 2'd3
  } status_t;

  typedef struct packed {
    op_t                   op;
    logic [QW-1:0]         q;
    logic [DATA_WIDTH-1:0] data;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] data;
    logic [1:0]  src;
    logic        last;
  } res_t;

  // queue number modulo NUM_QUEUES; input is below 2*NUM_QUEUES
  function automatic logic [QW-1:0] qid_wrap(input logic [1:0] v);
    logic [4:0] w;
    w = {3'b000, v};
    if (w >= 5'(NUM_QUEUES)) begin
      w = w - 5'(NUM_QUEUES);
    end
    return QW'(w);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] to_store(input logic [31:0] d);
    logic [63:0] w;
    w = {32'b0, d};
    return w[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] to_out(input logic [DATA_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    return w[31:0];
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [QW-1:0] qnum_inc(input logic [QW-1:0] p);
    return (p == QW'(NUM_QUEUES - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q,
                                              input logic [PW-1:0] p);
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

endpackage

[rtl/core/qoq_front.sv]
// ----------------------------------------------------------------------------
// qoq_front
// Accepts items, decodes the command and wraps the queue number, and holds
// them in a short command queue for the back end.
// ----------------------------------------------------------------------------
module qoq_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           command,
  input  logic [1:0]           queue_id,
  input  logic signed [31:0]   data_in,
  output logic                 cmd_valid,
  input  logic                 cmd_take,
  output qoq_pkg::cmd_t        cmd
);
  import qoq_pkg::*;

  cmd_t            entries [CQ_DEPTH];
  logic [CQW-1:0]  wr_ptr;
  logic [CQW-1:0]  rd_ptr;
  logic [CQCW-1:0] count;
  logic            do_push;
  logic            do_pop;
  cmd_t            decoded;

  assign full      = (count == CQCW'(CQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    decoded.op   = op_t'(command);
    decoded.q    = qid_wrap(queue_id);
    decoded.data = to_store(data_in);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CQW'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CQW'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/qoq_back.sv]
// ----------------------------------------------------------------------------
// qoq_back
// Executes commands: owns the element memory, the per-queue pointers and the
// main queue, and drains a released queue one element per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module qoq_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_take,
  input  qoq_pkg::cmd_t              cmd,
  input  logic [qoq_pkg::OQCW-1:0]   oq_count,
  output logic                       res_valid,
  output qoq_pkg::res_t              res
);
  import qoq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] rdata;

  logic [FW-1:0]  fill     [NUM_QUEUES];
  logic [PW-1:0]  rd_ptr   [NUM_QUEUES];
  logic [PW-1:0]  wr_ptr   [NUM_QUEUES];
  logic           attached [NUM_QUEUES];
  logic [QW-1:0]  main_order [NUM_QUEUES];
  logic [QW-1:0]  main_head;
  logic [QW-1:0]  main_tail;
  logic [MCW-1:0] main_count;

  logic           rd_pending;
  logic [QW-1:0]  pend_src;
  logic           pend_last;

  logic [QW-1:0]  rq;
  logic [PW-1:0]  dptr;
  logic [FW-1:0]  remain;

  logic [QW-1:0]  sel;
  logic [FW-1:0]  sel_fill;
  logic           sel_full;
  logic           sel_empty;
  logic           main_empty;
  logic           main_full;
  logic           exec;
  logic           drain_issue;
  logic           rd_issue;
  logic [AW-1:0]  raddr;
  logic           wr_en;
  logic           imm_valid;
  res_t           imm_res;

  // release works on the main queue's head, everything else on the item's queue
  assign sel        = (cmd.op == OP_RELEASE) ? main_order[main_head] : cmd.q;
  assign sel_fill   = fill[sel];
  assign sel_full   = (sel_fill == FW'(QUEUE_DEPTH));
  assign sel_empty  = (sel_fill == '0);
  assign main_empty = (main_count == '0);
  assign main_full  = (main_count == MCW'(NUM_QUEUES));

  // one result may be in flight through the memory read; count it as taken room
  assign exec = (state == S_IDLE) && cmd_valid && !rd_pending &&
                (oq_count < OQCW'(OQ_DEPTH));
  assign drain_issue = (state == S_DRAIN) &&
                       (({1'b0, oq_count} + (OQCW + 1)'(rd_pending)) <
                        (OQCW + 1)'(OQ_DEPTH));
  assign cmd_take = exec;

  assign rd_issue = (exec && (cmd.op == OP_POP) && !sel_empty) || drain_issue;
  assign raddr    = drain_issue ? slot_addr(rq, dptr) : slot_addr(sel, rd_ptr[sel]);
  assign wr_en    = exec && (cmd.op == OP_PUSH) && !sel_full;

  always_comb begin
    imm_valid      = 1'b0;
    imm_res.status = ST_OK;
    imm_res.data   = '0;
    imm_res.src    = 2'(sel);
    imm_res.last   = 1'b1;
    if (exec) begin
      unique case (cmd.op)
        OP_PUSH: begin
          imm_valid      = 1'b1;
          imm_res.status = sel_full ? ST_FULL : ST_OK;
        end
        OP_POP: begin
          imm_valid      = sel_empty;
          imm_res.status = ST_EMPTY;
          imm_res.data   = '1;
        end
        OP_ATTACH: begin
          imm_valid      = 1'b1;
          imm_res.status = (attached[sel] || main_full) ? ST_ATTACHED : ST_OK;
        end
        OP_RELEASE: begin
          imm_valid      = main_empty || sel_empty;
          imm_res.status = ST_EMPTY;
          if (main_empty) begin
            imm_res.src = '0;
          end
        end
        default: begin
          imm_valid = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (rd_pending) begin
      res_valid  = 1'b1;
      res.status = ST_OK;
      res.data   = to_out(rdata);
      res.src    = 2'(pend_src);
      res.last   = pend_last;
    end else begin
      res_valid = imm_valid;
      res       = imm_res;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (exec && (cmd.op == OP_RELEASE) && !main_empty && !sel_empty) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_issue && (remain == FW'(1))) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // element memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_addr(sel, wr_ptr[sel])] <= cmd.data;
    end
    if (rd_issue) begin
      rdata <= mem[raddr];
    end
  end

  // payload without reset
  always_ff @(posedge clk) begin
    if (exec && (cmd.op == OP_ATTACH) && !attached[sel] && !main_full) begin
      main_order[main_tail] <= sel;
    end
    if (exec && (cmd.op == OP_RELEASE)) begin
      rq     <= sel;
      dptr   <= rd_ptr[sel];
      remain <= sel_fill;
    end else if (drain_issue) begin
      dptr   <= ptr_inc(dptr);
      remain <= remain - 1'b1;
    end
    if (rd_issue) begin
      pend_src  <= drain_issue ? rq : sel;
      pend_last <= drain_issue ? (remain == FW'(1)) : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pending <= 1'b0;
      main_head  <= '0;
      main_tail  <= '0;
      main_count <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill[i]     <= '0;
        rd_ptr[i]   <= '0;
        wr_ptr[i]   <= '0;
        attached[i] <= 1'b0;
      end
    end else begin
      state      <= state_next;
      rd_pending <= rd_issue;
      if (exec) begin
        unique case (cmd.op)
          OP_PUSH: begin
            if (!sel_full) begin
              wr_ptr[sel] <= ptr_inc(wr_ptr[sel]);
              fill[sel]   <= sel_fill + 1'b1;
            end
          end
          OP_POP: begin
            if (!sel_empty) begin
              rd_ptr[sel] <= ptr_inc(rd_ptr[sel]);
              fill[sel]   <= sel_fill - 1'b1;
            end
          end
          OP_ATTACH: begin
            if (!attached[sel] && !main_full) begin
              attached[sel] <= 1'b1;
              main_tail     <= qnum_inc(main_tail);
              main_count    <= main_count + 1'b1;
            end
          end
          OP_RELEASE: begin
            if (!main_empty) begin
              main_head     <= qnum_inc(main_head);
              main_count    <= main_count - 1'b1;
              attached[sel] <= 1'b0;
              fill[sel]     <= '0;
              rd_ptr[sel]   <= '0;
              wr_ptr[sel]   <= '0;
            end
          end
          default: begin
            main_count <= main_count;
          end
        endcase
      end
    end
  end

endmodule

[rtl/core/qoq_outq.sv]
// ----------------------------------------------------------------------------
// qoq_outq
// Result queue: holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module qoq_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      res_valid,
  input  qoq_pkg::res_t             res,
  output logic [qoq_pkg::OQCW-1:0]  count,
  output logic                      empty,
  input  logic                      pop,
  output qoq_pkg::res_t             head
);
  import qoq_pkg::*;

  res_t           entries [OQ_DEPTH];
  logic [OQW-1:0] wr_ptr;
  logic [OQW-1:0] rd_ptr;
  logic           do_pop;

  // the back end only writes when it has checked for room
  assign empty  = (count == '0);
  assign head   = entries[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (res_valid) begin
      entries[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= (wr_ptr == OQW'(OQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == OQW'(OQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (res_valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !res_valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/queue_of_queues_buffer.sv]
// ----------------------------------------------------------------------------
// queue_of_queues_buffer
// Several small FIFOs of signed words plus a main FIFO of queue numbers;
// release of the main head streams out the whole attached queue.
// ----------------------------------------------------------------------------
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------
//  input    | push / full       | command, queue_id, data_in
//  result   | empty / pop       | status, data_out, source_queue, last
//
// Push, pop and attach are executed directly in the back end; a pop with data
// delivers its result after the registered memory read of the element.
// A release with elements streams one element per cycle while the result
// queue has room, limited by the single read port of the element memory.
// A full result queue stalls the back end; the two-entry command queue keeps
// taking items until both entries are used, then full rises. Reset clears the control state, not the stored data.
//
module queue_of_queues_buffer (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command,
  input  logic [1:0]         queue_id,
  input  logic signed [31:0] data_in,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic signed [31:0] data_out,
  output logic [1:0]         source_queue,
  output logic               last
);
  import qoq_pkg::*;

  logic            cmd_valid;
  logic            cmd_take;
  cmd_t            cmd;
  logic [OQCW-1:0] oq_count;
  logic            res_valid;
  res_t            res;
  res_t            head;

  // front: accept and decode items
  qoq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .queue_id  (queue_id),
    .data_in   (data_in),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  // back: state, element memory and release sequencer
  qoq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .oq_count  (oq_count),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue toward the consumer
  qoq_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .count     (oq_count),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign status       = head.status;
  assign data_out     = head.data;
  assign source_queue = head.src;
  assign last         = head.last;

endmodule
